@@ hdl/glms_pkg.sv @@
// Shared types, constants and helper functions for the guided Langevin
// Metropolis step block. No dependencies; all files but glms_ram import this package.
package glms_pkg;

   localparam int BEADS   = 16384;
   localparam int BEAD_AW = $clog2(BEADS);
   localparam int SUM_N   = 7;
   localparam int SUM_W   = 64;
   localparam int ROW_W   = SUM_N * SUM_W;

   localparam int DIV_NW = 63;
   localparam int DIV_DW = 40;
   localparam int DIV_CW = $clog2(DIV_NW);

   localparam logic [31:0] TIME_STEP_RST   = 32'd4294967;
   localparam logic [30:0] NOISE_SCALE_RST = 31'd4649438;
   localparam logic [30:0] INV_TEMP_RST    = 31'd111848107;
   localparam logic signed [31:0] START_POS_RST = -32'sd241591910;

   localparam logic signed [63:0] ONE_Q28   = 64'sd268435456;
   localparam logic [31:0]        LOG2E_Q30 = 32'd1549082005;
   localparam logic [31:0]        LN2_Q32   = 32'd2977044472;

   localparam int SUM_X         = 0;
   localparam int SUM_X_SQ      = 1;
   localparam int SUM_DU        = 2;
   localparam int SUM_FORCE     = 3;
   localparam int SUM_FORCE_DU  = 4;
   localparam int SUM_HALF_SQ   = 5;
   localparam int SUM_HALF_SQDU = 6;

   typedef enum logic [1:0] {
      CSR_TIME_STEP,
      CSR_NOISE_SCALE,
      CSR_INV_TEMP,
      CSR_START_POS
   } csr_index_type;

   typedef enum logic {
      OP_STEP,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [13:0]         bead_index;
      logic signed [31:0]  gauss_sample;
      logic [31:0]         uniform_sample;
      logic signed [31:0]  mean_here;
      logic signed [31:0]  mean_next;
      logic signed [31:0]  stiffness_here;
      logic signed [31:0]  stiffness_next;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  new_position;
      logic                accepted;
      logic signed [63:0]  sum_x;
      logic signed [63:0]  sum_x_sq;
      logic signed [63:0]  sum_du;
      logic signed [63:0]  sum_force;
      logic signed [63:0]  sum_force_du;
      logic signed [63:0]  sum_half_sq;
      logic signed [63:0]  sum_half_sq_du;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0]  a;
      logic signed [63:0]  b;
      logic [5:0]          sh;
   } mul_req_type;

   typedef struct packed {
      logic [DIV_NW-1:0]   dividend;
      logic [DIV_DW-1:0]   divisor;
   } div_req_type;

   function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

   // Reciprocal of k scaled by 2^36, rounded down.
   function automatic logic [36:0] recip(logic [3:0] k);
      logic [36:0] r;
      case (k)
         4'd1:    r = 37'd68719476736;
         4'd2:    r = 37'd34359738368;
         4'd3:    r = 37'd22906492245;
         4'd4:    r = 37'd17179869184;
         4'd5:    r = 37'd13743895347;
         4'd6:    r = 37'd11453246122;
         4'd7:    r = 37'd9817068105;
         4'd8:    r = 37'd8589934592;
         4'd9:    r = 37'd7635497415;
         4'd10:   r = 37'd6871947673;
         default: r = 37'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/glms_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module glms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/glms_mul.sv @@
// Multi-cycle signed multiply with floor shift and 64-bit saturation, built on
// one 32x32 multiplier. Depends on glms_pkg.
module glms_mul import glms_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mul_req_type        req,
   output logic               done,
   output logic signed [63:0] result
);

   typedef enum logic [1:0] {M_IDLE, M_PP, M_SHIFT, M_SAT} mstate_type;

   mstate_type         st_ff;
   logic [63:0]        ua_ff, ub_ff;
   logic               neg_ff;
   logic [5:0]         sh_ff;
   logic [1:0]         cnt_ff;
   logic [127:0]       acc_ff, mag_ff;
   logic               rem_ff;
   logic               done_ff;
   logic signed [63:0] result_ff;

   logic [31:0]  a_part, b_part;
   logic [63:0]  pp;
   logic [127:0] pp_sh, acc_in, shifted, mask;
   logic         rem;
   logic [64:0]  lo65;
   logic         big;
   logic [63:0]  low;
   logic signed [63:0] sat;

   always_comb begin
      a_part = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      b_part = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp = a_part * b_part;
      case (cnt_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
      acc_in  = acc_ff + pp_sh;
      shifted = acc_ff >> sh_ff;
      mask    = (128'd1 << sh_ff) - 128'd1;
      rem     = |(acc_ff & mask);
      lo65    = {1'b0, mag_ff[63:0]} + {64'd0, neg_ff & rem_ff};
      big     = (|mag_ff[127:64]) | lo65[64];
      low     = lo65[63:0];
      if (neg_ff) begin
         if (big || (low > 64'h8000_0000_0000_0000)) begin
            sat = {1'b1, 63'd0};
         end else begin
            sat = -$signed(low);
         end
      end else begin
         if (big || low[63]) begin
            sat = {1'b0, {63{1'b1}}};
         end else begin
            sat = $signed(low);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= M_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            M_IDLE: begin
               if (start) begin
                  ua_ff  <= req.a[63] ? 64'd0 - req.a : req.a;
                  ub_ff  <= req.b[63] ? 64'd0 - req.b : req.b;
                  neg_ff <= req.a[63] ^ req.b[63];
                  sh_ff  <= req.sh;
                  cnt_ff <= 2'd0;
                  acc_ff <= '0;
                  st_ff  <= M_PP;
               end
            end
            M_PP: begin
               acc_ff <= acc_in;
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  st_ff <= M_SHIFT;
               end
            end
            M_SHIFT: begin
               mag_ff <= shifted;
               rem_ff <= rem;
               st_ff  <= M_SAT;
            end
            M_SAT: begin
               result_ff <= sat;
               done_ff   <= 1'b1;
               st_ff     <= M_IDLE;
            end
            default: st_ff <= M_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ hdl/glms_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on glms_pkg.
module glms_div import glms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  div_req_type       req,
   output logic              done,
   output logic [DIV_NW-1:0] quotient
);

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type        st_ff;
   logic [DIV_NW-1:0] dvd_ff;
   logic [DIV_DW-1:0] dvs_ff;
   logic [DIV_DW-1:0] rem_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              done_ff;

   logic [DIV_DW:0] trial;
   logic            ge;
   logic [DIV_DW:0] diff;

   always_comb begin
      trial = {rem_ff, dvd_ff[DIV_NW-1]};
      ge    = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= D_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            D_IDLE: begin
               if (start) begin
                  dvd_ff <= req.dividend;
                  dvs_ff <= req.divisor;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  st_ff  <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
               dvd_ff <= {dvd_ff[DIV_NW-2:0], ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
                  done_ff <= 1'b1;
                  st_ff   <= D_IDLE;
               end
            end
            default: st_ff <= D_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ hdl/guided_langevin_metropolis_step.sv @@
// Guided Langevin step with Metropolis accept/reject and per-bead saturating sums.
// Depends on glms_pkg, glms_ram, glms_mul and glms_div.
//
// After reset the block runs a clearing pass over the bead-sum memory, one bead
// per cycle over all BEADS (16384) beads, and takes no item until it ends; register
// writes are taken meanwhile. A step item takes longer when the exponential is
// evaluated than when the energy change decides acceptance at once; its time is
// set by the sequencer issuing every product, one after another, to a single
// multiply unit built on a 32x32 multiplier, plus a restoring divide.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken.
module guided_langevin_metropolis_step import glms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_RD, S_CAP, S_RUN, S_MWAIT, S_DWAIT, S_FIN
   } state_type;

   typedef enum logic [4:0] {
      ST_V, ST_P, ST_T3, ST_R, ST_DIV, ST_D0, ST_E0, ST_D1, ST_E1, ST_Y,
      ST_Z, ST_T, ST_W, ST_QK, ST_CORR, ST_PROB, ST_POS,
      ST_SQ, ST_S1, ST_S2, ST_S3, ST_FR, ST_HS,
      ST_TX, ST_TXX, ST_TDU, ST_TF, ST_TFDU, ST_THS, ST_THSDU, ST_DONE
   } step_type;

   logic [31:0]        time_step_ff;
   logic [30:0]        noise_scale_ff;
   logic [30:0]        inv_temp_ff;
   logic signed [31:0] start_pos_ff;

   state_type          state_ff;
   step_type           step_ff;
   logic [BEAD_AW-1:0] clr_ff;
   req_type            item_ff;
   logic signed [31:0] prev_ff, x0_ff, x1_ff, pos_ff;
   logic               acc_ff;
   logic signed [63:0] v_ff, p_ff, dtmp_ff, e0_ff, e1_ff, y_ff;
   logic signed [63:0] sq_ff, s1_ff, du_ff, fr_ff, hs_ff;
   logic signed [38:0] num_ff;
   logic signed [40:0] den_ff;
   logic [4:0]         n_ff;
   logic [31:0]        t_ff;
   logic [32:0]        s_ff, w_ff, qe_ff;
   logic [3:0]         k_ff;
   logic [SUM_N-1:0][SUM_W-1:0] sums_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               cfg_wr;
   logic               bead_ok;
   logic [BEAD_AW-1:0] bead_addr;
   logic signed [32:0] m0_x0, m0_x1, m1_x0, m1_x1, d0, e;
   logic signed [33:0] neg_e;
   mul_req_type        mreq;
   logic               mul_start, mul_done;
   logic signed [63:0] mres;
   div_req_type        dreq;
   logic               div_start, div_done;
   logic [DIV_NW-1:0]  dquot;
   logic [38:0]        num_mag;
   logic [39:0]        den_mag;
   logic               ram_wr_en, ram_rd_en;
   logic [BEAD_AW-1:0] ram_wr_addr;
   logic [ROW_W-1:0]   ram_wr_data, ram_rd_data;
   logic [36:0]        corr_prod, corr_rem;
   logic [32:0]        corr_q, prob;
   logic signed [39:0] q_zero_den;

   function automatic logic signed [38:0] clamp_num(logic signed [65:0] v);
      logic signed [38:0] r;
      if (v > 66'sd274877906943) begin
         r = {1'b0, {38{1'b1}}};
      end else if (v < -66'sd274877906944) begin
         r = {1'b1, 38'd0};
      end else begin
         r = v[38:0];
      end
      return r;
   endfunction

   function automatic logic signed [39:0] sat_quot(logic [DIV_NW-1:0] uq, logic neg);
      logic signed [39:0] r;
      if (neg) begin
         if (uq > DIV_NW'(64'd549755813888)) begin
            r = {1'b1, 39'd0};
         end else begin
            r = -$signed(uq[39:0]);
         end
      end else begin
         if (uq > DIV_NW'(64'd549755813887)) begin
            r = {1'b0, {39{1'b1}}};
         end else begin
            r = $signed(uq[39:0]);
         end
      end
      return r;
   endfunction

   function automatic logic signed [31:0] x1_of(logic signed [31:0] m1, logic signed [39:0] q);
      logic signed [41:0] s;
      logic signed [31:0] r;
      s = 42'(m1) + 42'(q);
      if (s > 42'sd2147483647) begin
         r = {1'b0, {31{1'b1}}};
      end else if (s < -42'sd2147483648) begin
         r = {1'b1, 31'd0};
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   // Register port.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= TIME_STEP_RST;
         noise_scale_ff <= NOISE_SCALE_RST;
         inv_temp_ff    <= INV_TEMP_RST;
         start_pos_ff   <= START_POS_RST;
      end else if (cfg_wr) begin
         case (csr_index_type'(paddr[3:2]))
            CSR_TIME_STEP:   time_step_ff   <= pwdata;
            CSR_NOISE_SCALE: noise_scale_ff <= pwdata[30:0];
            CSR_INV_TEMP:    inv_temp_ff    <= pwdata[30:0];
            CSR_START_POS:   start_pos_ff   <= $signed(pwdata);
            default:         time_step_ff   <= time_step_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(paddr[3:2]))
         CSR_TIME_STEP:   prdata = time_step_ff;
         CSR_NOISE_SCALE: prdata = {1'b0, noise_scale_ff};
         CSR_INV_TEMP:    prdata = {1'b0, inv_temp_ff};
         CSR_START_POS:   prdata = start_pos_ff;
         default:         prdata = '0;
      endcase
   end

   // Operand preparation.
   assign bead_ok   = 32'(item_ff.bead_index) < BEADS;
   assign bead_addr = BEAD_AW'(item_ff.bead_index);
   assign m0_x0 = 33'(item_ff.mean_here) - 33'(x0_ff);
   assign m0_x1 = 33'(item_ff.mean_here) - 33'(x1_ff);
   assign m1_x0 = 33'(item_ff.mean_next) - 33'(x0_ff);
   assign m1_x1 = 33'(item_ff.mean_next) - 33'(x1_ff);
   assign d0    = 33'(pos_ff) - 33'(item_ff.mean_here);
   assign e     = 33'(pos_ff) - 33'(item_ff.mean_next);
   assign neg_e = 34'(item_ff.mean_next) - 34'(pos_ff);

   always_comb begin
      mreq = '0;
      case (step_ff)
         ST_V:     mreq = '{a: {33'd0, noise_scale_ff}, b: 64'(item_ff.gauss_sample), sh: 6'd28};
         ST_P:     mreq = '{a: 64'(item_ff.stiffness_here), b: 64'(m0_x0), sh: 6'd16};
         ST_T3:    mreq = '{a: p_ff, b: {32'd0, time_step_ff}, sh: 6'd33};
         ST_R:     mreq = '{a: 64'(item_ff.stiffness_next), b: {32'd0, time_step_ff}, sh: 6'd25};
         ST_D0:    mreq = '{a: 64'(m0_x0), b: 64'(m0_x1), sh: 6'd28};
         ST_E0:    mreq = '{a: 64'(item_ff.stiffness_here), b: dtmp_ff, sh: 6'd17};
         ST_D1:    mreq = '{a: 64'(m1_x0), b: 64'(m1_x1), sh: 6'd28};
         ST_E1:    mreq = '{a: 64'(item_ff.stiffness_next), b: dtmp_ff, sh: 6'd17};
         ST_Y:     mreq = '{a: e1_ff - e0_ff, b: {33'd0, inv_temp_ff}, sh: 6'd24};
         ST_Z:     mreq = '{a: y_ff, b: {32'd0, LOG2E_Q30}, sh: 6'd30};
         ST_T:     mreq = '{a: {32'd0, t_ff}, b: {32'd0, LN2_Q32}, sh: 6'd28};
         ST_W:     mreq = '{a: {32'd0, t_ff}, b: {31'd0, s_ff}, sh: 6'd32};
         ST_QK:    mreq = '{a: {31'd0, w_ff}, b: {27'd0, recip(k_ff)}, sh: 6'd36};
         ST_SQ:    mreq = '{a: 64'(pos_ff), b: 64'(pos_ff), sh: 6'd28};
         ST_S1:    mreq = '{a: sq_ff, b: sq_ff, sh: 6'd28};
         ST_S2:    mreq = '{a: 64'(d0), b: 64'(d0), sh: 6'd28};
         ST_S3:    mreq = '{a: 64'(item_ff.stiffness_here), b: dtmp_ff, sh: 6'd17};
         ST_FR:    mreq = '{a: 64'(neg_e), b: 64'(item_ff.stiffness_next), sh: 6'd16};
         ST_HS:    mreq = '{a: 64'(e), b: 64'(e), sh: 6'd29};
         ST_TX:    mreq = '{a: 64'(pos_ff), b: 64'sd4096, sh: 6'd0};
         ST_TXX:   mreq = '{a: 64'(pos_ff), b: 64'(pos_ff), sh: 6'd16};
         ST_TDU:   mreq = '{a: du_ff, b: 64'sd4096, sh: 6'd0};
         ST_TF:    mreq = '{a: fr_ff, b: 64'sd4096, sh: 6'd0};
         ST_TFDU:  mreq = '{a: fr_ff, b: du_ff, sh: 6'd16};
         ST_THS:   mreq = '{a: 64'(e), b: 64'(e), sh: 6'd17};
         ST_THSDU: mreq = '{a: hs_ff, b: du_ff, sh: 6'd16};
         default:  mreq = '0;
      endcase
   end

   assign mul_start = (state_ff == S_RUN) &&
                      !(step_ff inside {ST_DIV, ST_CORR, ST_PROB, ST_POS, ST_DONE});

   assign num_mag   = num_ff[38] ? 39'd0 - num_ff : num_ff;
   assign den_mag   = den_ff[40] ? 40'(41'd0 - den_ff) : den_ff[39:0];
   assign dreq      = '{dividend: {num_mag, 24'd0}, divisor: den_mag};
   assign div_start = (state_ff == S_RUN) && (step_ff == ST_DIV) && (den_ff != '0);

   always_comb begin
      if (num_ff > 0) begin
         q_zero_den = {1'b0, {39{1'b1}}};
      end else if (num_ff < 0) begin
         q_zero_den = {1'b1, 39'd0};
      end else begin
         q_zero_den = '0;
      end
   end

   assign corr_prod = 37'(qe_ff) * 37'(k_ff);
   assign corr_rem  = 37'(w_ff) - corr_prod;
   assign corr_q    = qe_ff + {32'd0, corr_rem >= 37'(k_ff)};
   assign prob      = s_ff >> n_ff;

   glms_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .req    (mreq),
      .done   (mul_done),
      .result (mres)
   );

   glms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (dreq),
      .done     (div_done),
      .quotient (dquot)
   );

   assign ram_wr_en   = (state_ff == S_CLEAR) ||
                        ((state_ff == S_RUN) && (step_ff == ST_DONE) && bead_ok);
   assign ram_wr_addr = (state_ff == S_CLEAR) ? clr_ff : bead_addr;
   assign ram_wr_data = (state_ff == S_CLEAR) ? '0 : sums_ff;
   assign ram_rd_en   = (state_ff == S_RD);

   glms_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BEADS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (bead_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= ST_V;
         clr_ff       <= '0;
         prev_ff      <= START_POS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BEAD_AW'(BEADS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_CAP;
            end
            S_CAP: begin
               sums_ff <= bead_ok ? ram_rd_data : '0;
               x0_ff   <= (item_ff.bead_index == '0) ? start_pos_ff : prev_ff;
               pos_ff  <= prev_ff;
               acc_ff  <= 1'b0;
               step_ff <= ST_V;
               state_ff <= (item_ff.op == OP_READ) ? S_FIN : S_RUN;
            end
            S_RUN: begin
               case (step_ff)
                  ST_DIV: begin
                     if (den_ff == '0) begin
                        x1_ff   <= x1_of(item_ff.mean_next, q_zero_den);
                        step_ff <= ST_D0;
                     end else begin
                        state_ff <= S_DWAIT;
                     end
                  end
                  ST_CORR: begin
                     s_ff <= 33'h1_0000_0000 - corr_q;
                     k_ff <= k_ff - 4'd1;
                     step_ff <= (k_ff == 4'd1) ? ST_PROB : ST_W;
                  end
                  ST_PROB: begin
                     acc_ff  <= prob >= {1'b0, item_ff.uniform_sample};
                     step_ff <= ST_POS;
                  end
                  ST_POS: begin
                     pos_ff  <= acc_ff ? x1_ff : x0_ff;
                     prev_ff <= acc_ff ? x1_ff : x0_ff;
                     step_ff <= bead_ok ? ST_SQ : ST_DONE;
                  end
                  ST_DONE: begin
                     state_ff <= S_FIN;
                  end
                  default: begin
                     state_ff <= S_MWAIT;
                  end
               endcase
            end
            S_MWAIT: begin
               if (mul_done) begin
                  state_ff <= S_RUN;
                  case (step_ff)
                     ST_V: begin
                        v_ff <= mres;
                        step_ff <= ST_P;
                     end
                     ST_P: begin
                        p_ff <= mres;
                        step_ff <= ST_T3;
                     end
                     ST_T3: begin
                        num_ff <= clamp_num(66'(x0_ff) - 66'(item_ff.mean_next)
                                            + 66'(v_ff) + 66'(mres));
                        step_ff <= ST_R;
                     end
                     ST_R: begin
                        den_ff <= 41'(mres) + 41'sd16777216;
                        step_ff <= ST_DIV;
                     end
                     ST_D0: begin
                        dtmp_ff <= mres;
                        step_ff <= ST_E0;
                     end
                     ST_E0: begin
                        e0_ff <= mres;
                        step_ff <= ST_D1;
                     end
                     ST_D1: begin
                        dtmp_ff <= mres;
                        step_ff <= ST_E1;
                     end
                     ST_E1: begin
                        e1_ff <= mres;
                        step_ff <= ST_Y;
                     end
                     ST_Y: begin
                        y_ff <= mres;
                        if (mres <= 64'sd0) begin
                           acc_ff  <= 1'b1;
                           step_ff <= ST_POS;
                        end else if (mres >= 64'sd8589934592) begin
                           acc_ff  <= (item_ff.uniform_sample == '0);
                           step_ff <= ST_POS;
                        end else begin
                           step_ff <= ST_Z;
                        end
                     end
                     ST_Z: begin
                        if (|mres[63:33]) begin
                           acc_ff  <= (item_ff.uniform_sample == '0);
                           step_ff <= ST_POS;
                        end else begin
                           n_ff    <= mres[32:28];
                           t_ff    <= {4'd0, mres[27:0]};
                           step_ff <= ST_T;
                        end
                     end
                     ST_T: begin
                        t_ff    <= mres[31:0];
                        s_ff    <= 33'h1_0000_0000;
                        k_ff    <= 4'd10;
                        step_ff <= ST_W;
                     end
                     ST_W: begin
                        w_ff    <= mres[32:0];
                        step_ff <= ST_QK;
                     end
                     ST_QK: begin
                        qe_ff   <= mres[32:0];
                        step_ff <= ST_CORR;
                     end
                     ST_SQ: begin
                        sq_ff   <= mres - ONE_Q28;
                        step_ff <= ST_S1;
                     end
                     ST_S1: begin
                        s1_ff   <= mres;
                        step_ff <= ST_S2;
                     end
                     ST_S2: begin
                        dtmp_ff <= mres;
                        step_ff <= ST_S3;
                     end
                     ST_S3: begin
                        du_ff   <= s1_ff - mres;
                        step_ff <= ST_FR;
                     end
                     ST_FR: begin
                        fr_ff   <= mres;
                        step_ff <= ST_HS;
                     end
                     ST_HS: begin
                        hs_ff   <= mres;
                        step_ff <= ST_TX;
                     end
                     ST_TX: begin
                        sums_ff[SUM_X] <= sadd($signed(sums_ff[SUM_X]), mres);
                        step_ff <= ST_TXX;
                     end
                     ST_TXX: begin
                        sums_ff[SUM_X_SQ] <= sadd($signed(sums_ff[SUM_X_SQ]), mres);
                        step_ff <= ST_TDU;
                     end
                     ST_TDU: begin
                        sums_ff[SUM_DU] <= sadd($signed(sums_ff[SUM_DU]), mres);
                        step_ff <= ST_TF;
                     end
                     ST_TF: begin
                        sums_ff[SUM_FORCE] <= sadd($signed(sums_ff[SUM_FORCE]), mres);
                        step_ff <= ST_TFDU;
                     end
                     ST_TFDU: begin
                        sums_ff[SUM_FORCE_DU] <= sadd($signed(sums_ff[SUM_FORCE_DU]), mres);
                        step_ff <= ST_THS;
                     end
                     ST_THS: begin
                        sums_ff[SUM_HALF_SQ] <= sadd($signed(sums_ff[SUM_HALF_SQ]), mres);
                        step_ff <= ST_THSDU;
                     end
                     ST_THSDU: begin
                        sums_ff[SUM_HALF_SQDU] <= sadd($signed(sums_ff[SUM_HALF_SQDU]), mres);
                        step_ff <= ST_DONE;
                     end
                     default: step_ff <= ST_DONE;
                  endcase
               end
            end
            S_DWAIT: begin
               if (div_done) begin
                  x1_ff    <= x1_of(item_ff.mean_next,
                                    sat_quot(dquot, num_ff[38] ^ den_ff[40]));
                  step_ff  <= ST_D0;
                  state_ff <= S_RUN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.new_position    <= pos_ff;
                  rsp_data_ff.accepted        <= acc_ff;
                  rsp_data_ff.sum_x           <= sums_ff[SUM_X];
                  rsp_data_ff.sum_x_sq        <= sums_ff[SUM_X_SQ];
                  rsp_data_ff.sum_du          <= sums_ff[SUM_DU];
                  rsp_data_ff.sum_force       <= sums_ff[SUM_FORCE];
                  rsp_data_ff.sum_force_du    <= sums_ff[SUM_FORCE_DU];
                  rsp_data_ff.sum_half_sq     <= sums_ff[SUM_HALF_SQ];
                  rsp_data_ff.sum_half_sq_du  <= sums_ff[SUM_HALF_SQDU];
                  state_ff                    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
